// ----- sv/blep_pkg.sv -----
// Shared constants, types and the step residual table for the band-limited step corrector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package blep_pkg;

	localparam int TAPS       = 8;
	localparam int STEP       = 5;
	localparam int ROM_OFFSET = 5;
	localparam int RING_DEPTH = 8;
	localparam int ROM_SIZE   = 48;

	localparam int OFFSET_W = 17;
	localparam int AMP_W    = 17;
	localparam int SAMPLE_W = 32;
	localparam int PEND_W   = 4;
	localparam int FRAC_W   = 16;
	localparam int COEF_W   = 16;
	localparam int TERM_W   = AMP_W + COEF_W + 1;

	localparam int POS_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int TAP_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int SCALED_W  = OFFSET_W + $clog2(STEP + 1);
	localparam int PHASE_W   = SCALED_W - FRAC_W;
	localparam int ROM_IDX_W = $clog2(ROM_SIZE);
	localparam int SRC_MAX   = STEP + ROM_OFFSET + (TAPS - 1) * STEP + 1;
	localparam int SRC_W     = ($clog2(SRC_MAX + 1) > ROM_IDX_W) ?
		$clog2(SRC_MAX + 1) : ROM_IDX_W;

	localparam logic [OFFSET_W-1:0] OFFSET_ONE = OFFSET_W'(65536);
	localparam logic                CMD_ADD    = 1'b0;
	localparam logic                CMD_RUN    = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_DRAIN,
		ST_RUN
	} blep_state_t;

	// One tap handed to the coefficient pipeline.
	typedef struct packed {
		logic             vld;
		logic [SRC_W-1:0] src;
		logic [POS_W-1:0] pos;
	} tap_req_t;

	// Ring access requests coming back from the coefficient pipeline.
	typedef struct packed {
		logic             rd_vld;
		logic [POS_W-1:0] rd_pos;
		logic             wr_vld;
		logic [POS_W-1:0] wr_pos;
		logic             busy;
	} tap_stat_t;

	localparam logic signed [COEF_W-1:0] STEP_ROM [ROM_SIZE] = '{
		16'sd32753, 16'sd32747, 16'sd32747, 16'sd32746, 16'sd32727, 16'sd32657,
		16'sd32480, 16'sd32102, 16'sd31384, 16'sd30138, 16'sd28158, 16'sd25262,
		16'sd21363, 16'sd16532, 16'sd11058, 16'sd5437,  16'sd312,   -16'sd3660,
		-16'sd5954, -16'sd6428, -16'sd5206, -16'sd2851, -16'sd131,  16'sd2177,
		16'sd3502,  16'sd3629,  16'sd2720,  16'sd1268,  -16'sd193,  -16'sd1184,
		-16'sd1477, -16'sd1123, -16'sd384,  16'sd397,   16'sd937,   16'sd1107,
		16'sd940,   16'sd584,   16'sd229,   16'sd0,     16'sd0,     16'sd0,
		16'sd0,     16'sd0,     16'sd0,     16'sd0,     16'sd0,     16'sd0
	};

	// Entries past the end of the table read as zero.
	function automatic logic signed [COEF_W-1:0] rom_coef(input logic [SRC_W-1:0] idx);
		logic signed [COEF_W-1:0] v;
		v = '0;
		if (idx < SRC_W'(ROM_SIZE)) begin
			v = STEP_ROM[idx[ROM_IDX_W-1:0]];
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- sv/blep_item_if.sv -----
// Input channel: command, offset and amplitude with valid/ready.
// Depends on blep_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface blep_item_if;
	import blep_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [OFFSET_W-1:0]        offset;
	logic signed [AMP_W-1:0]    amplitude;

	modport source (output valid, output cmd, output offset, output amplitude, input ready);
	modport sink   (input valid, input cmd, input offset, input amplitude, output ready);
endinterface
`default_nettype wire

// ----- sv/blep_result_if.sv -----
// Output channel: correction sample and pending count with valid/ready.
// Depends on blep_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface blep_result_if;
	import blep_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic [PEND_W-1:0]          pending;

	modport source (output valid, output sample, output pending, input ready);
	modport sink   (input valid, input sample, input pending, output ready);
endinterface
`default_nettype wire

// ----- sv/blep_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module blep_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output      logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data until the next read
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- sv/blep_interp.sv -----
// Coefficient pipeline: table lookup, fractional interpolation, amplitude scaling.
// Depends on blep_pkg.
`timescale 1ns / 1ps
`default_nettype none
module blep_interp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire blep_pkg::tap_req_t                 req,
	input  wire logic [blep_pkg::FRAC_W-1:0]        frac,
	input  wire logic signed [blep_pkg::AMP_W-1:0]  amp,
	output      blep_pkg::tap_stat_t                stat,
	output      logic signed [blep_pkg::TERM_W-1:0] term
);
	import blep_pkg::*;

	localparam int DIFF_W = COEF_W + 1;
	localparam int PROD_W = DIFF_W + FRAC_W + 1;
	localparam int QUOT_W = PROD_W + 1 - FRAC_W;

	logic                       v_s1, v_s2, v_s3;
	logic [POS_W-1:0]           pos_s1, pos_s2, pos_s3;
	logic signed [COEF_W-1:0]   a_s1, a_s2;
	logic signed [DIFF_W-1:0]   d_s1;
	logic signed [PROD_W-1:0]   p_s2;
	logic signed [TERM_W-1:0]   term_s3;

	logic signed [COEF_W-1:0]   coef_a, coef_b;
	logic signed [PROD_W:0]     rnd;
	logic signed [QUOT_W-1:0]   quot;
	logic signed [QUOT_W-1:0]   c_wide;
	logic signed [DIFF_W-1:0]   c;

	always_comb begin
		coef_a = rom_coef(req.src);
		coef_b = rom_coef(req.src + SRC_W'(1));
		// add half, then floor by an arithmetic shift
		rnd    = {p_s2[PROD_W-1], p_s2} + (PROD_W+1)'(32768);
		quot   = rnd[PROD_W:FRAC_W];
		c_wide = QUOT_W'(a_s2) + quot;
		c      = c_wide[DIFF_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= coef_a;
		d_s1    <= DIFF_W'(coef_b) - DIFF_W'(coef_a);
		pos_s1  <= req.pos;
		a_s2    <= a_s1;
		p_s2    <= PROD_W'(d_s1) * PROD_W'($signed({1'b0, frac}));
		pos_s2  <= pos_s1;
		term_s3 <= TERM_W'(amp) * TERM_W'(c);
		pos_s3  <= pos_s2;
	end

	always_comb begin
		stat.rd_vld = v_s2;
		stat.rd_pos = pos_s2;
		stat.wr_vld = v_s3;
		stat.wr_pos = pos_s3;
		stat.busy   = v_s1 | v_s2;
		term        = term_s3;
	end
endmodule
`default_nettype wire

// ----- sv/blep_step_synthesizer_unit.sv -----
// Band-limited step corrector top level: sequencer, ring memory and result register.
// Depends on blep_pkg, blep_item_if, blep_result_if, blep_ram and blep_interp.
`timescale 1ns / 1ps
`default_nettype none
// A transfer with cmd = add places a band-limited step of the given amplitude at a
// sub-sample offset (Q0.16, 65536 = 1.0; larger offsets are dropped) into an 8-entry ring
// of 32-bit Q.15 correction sums, starting at the read position, and sets the pending
// count to 8. A transfer with cmd = run returns the sum at the read position, clears that
// entry, advances the ring and decrements the pending count (held at zero). Each add walks
// the 8 taps through the ring memory, one read-modify-write per cycle behind a three-stage
// coefficient pipeline; the next item is taken once the last write-back has landed. A run
// waits for the registered memory read; a dropped add leaves the unit idle. Add produces no
// result transfer; run produces exactly one. The result register lets a new item enter
// while a finished sample waits; a second run waits for that register to free up.
// The ring comes out of reset all zero through per-entry valid flags, with no clearing pass.
module blep_step_synthesizer_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	blep_item_if.sink     item,
	blep_result_if.source result
);
	import blep_pkg::*;

	blep_state_t                 state_q, state_d;
	logic [SRC_W-1:0]            src_q;
	logic [POS_W-1:0]            pos_q;
	logic [TAP_W-1:0]            tap_q;
	logic [FRAC_W-1:0]           frac_q;
	logic signed [AMP_W-1:0]     amp_q;
	logic [POS_W-1:0]            rd_pos_q;
	logic [PEND_W-1:0]           pending_q;
	logic [RING_DEPTH-1:0]       ent_vld_q;
	logic                        run_vld_q;
	logic                        out_vld_q;
	logic signed [SAMPLE_W-1:0]  sample_q;
	logic [PEND_W-1:0]           pend_out_q;

	logic                        acc, add_go, run_go, issue, load_out, last_tap;
	logic [SCALED_W-1:0]         scaled;
	logic [SRC_W-1:0]            src0;
	tap_req_t                    req;
	tap_stat_t                   stat;
	logic signed [TERM_W-1:0]    term;
	logic                        ram_re;
	logic [POS_W-1:0]            ram_raddr;
	logic [SAMPLE_W-1:0]         ram_rdata;
	logic signed [SAMPLE_W-1:0]  old_sum;
	logic signed [SAMPLE_W+2:0]  sum_wide;
	logic signed [SAMPLE_W-1:0]  sum_sat;

	function automatic logic [POS_W-1:0] ring_next(input logic [POS_W-1:0] p);
		return (p == POS_W'(RING_DEPTH - 1)) ? '0 : p + POS_W'(1);
	endfunction

	// Transfer decode.
	always_comb begin
		acc      = item.valid & item.ready;
		add_go   = acc & (item.cmd == CMD_ADD) & (item.offset <= OFFSET_ONE);
		run_go   = acc & (item.cmd == CMD_RUN);
		scaled   = SCALED_W'(item.offset) * SCALED_W'(STEP);
		src0     = SRC_W'(scaled[SCALED_W-1:FRAC_W]) + SRC_W'(ROM_OFFSET);
		last_tap = (tap_q == TAP_W'(TAPS - 1));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (add_go) begin
					state_d = ST_ADD;
				end else if (run_go) begin
					state_d = ST_RUN;
				end
			end
			ST_ADD: begin
				if (last_tap) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last write-back lands at this edge once stages one and two are empty
				if (!stat.busy) begin
					state_d = ST_IDLE;
				end
			end
			ST_RUN: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		item.ready = 1'b0;
		issue      = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			ST_IDLE:  item.ready = 1'b1;
			ST_ADD:   issue = 1'b1;
			ST_DRAIN: issue = 1'b0;
			ST_RUN:   load_out = !out_vld_q || result.ready;
			default:  item.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_pos_q  <= '0;
			pending_q <= '0;
			ent_vld_q <= '0;
			out_vld_q <= 1'b0;
			tap_q     <= '0;
		end else begin
			state_q <= state_d;
			if (add_go) begin
				pending_q <= PEND_W'(TAPS);
				tap_q     <= '0;
			end
			if (issue) begin
				tap_q <= tap_q + TAP_W'(1);
			end
			if (run_go) begin
				// clear the slot by dropping its valid flag, advance the ring
				ent_vld_q[rd_pos_q] <= 1'b0;
				rd_pos_q            <= ring_next(rd_pos_q);
				if (pending_q != '0) begin
					pending_q <= pending_q - PEND_W'(1);
				end
			end
			if (stat.wr_vld) begin
				ent_vld_q[stat.wr_pos] <= 1'b1;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Per-add operands (held stable while the pipeline runs), tap walk and run result capture.
	always_ff @(posedge clk) begin
		if (add_go) begin
			src_q  <= src0;
			pos_q  <= rd_pos_q;
			frac_q <= scaled[FRAC_W-1:0];
			amp_q  <= item.amplitude;
		end
		if (issue) begin
			src_q <= src_q + SRC_W'(STEP);
			pos_q <= ring_next(pos_q);
		end
		if (run_go) begin
			run_vld_q <= ent_vld_q[rd_pos_q];
		end
		if (load_out) begin
			sample_q   <= run_vld_q ? $signed(ram_rdata) : '0;
			pend_out_q <= pending_q;
		end
	end

	always_comb begin
		req.vld = issue;
		req.src = src_q;
		req.pos = pos_q;
	end

	blep_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.frac   (frac_q),
		.amp    (amp_q),
		.stat   (stat),
		.term   (term)
	);

	// Ring read: a run reads the read position, an add reads one stage ahead of write-back.
	always_comb begin
		ram_re    = run_go | stat.rd_vld;
		ram_raddr = run_go ? rd_pos_q : stat.rd_pos;
		old_sum   = ent_vld_q[stat.wr_pos] ? $signed(ram_rdata) : '0;
		sum_wide  = (SAMPLE_W+3)'(old_sum) + (SAMPLE_W+3)'(term);
		// saturate to the signed 32-bit range
		if (sum_wide[SAMPLE_W+2:SAMPLE_W-1] == '0 || sum_wide[SAMPLE_W+2:SAMPLE_W-1] == '1) begin
			sum_sat = sum_wide[SAMPLE_W-1:0];
		end else if (sum_wide[SAMPLE_W+2]) begin
			sum_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	blep_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (stat.wr_vld),
		.waddr (stat.wr_pos),
		.wdata (sum_sat),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		result.valid   = out_vld_q;
		result.sample  = sample_q;
		result.pending = pend_out_q;
	end

`ifndef SYNTH
	a_wr_only_in_add: assert property (@(posedge clk) disable iff (!arst_n)
		stat.wr_vld |-> (state_q == ST_ADD || state_q == ST_DRAIN))
		else $error("ring write outside an add");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> (!stat.busy && !stat.wr_vld))
		else $error("item taken while the tap pipeline is busy");
	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= PEND_W'(TAPS))
		else $error("pending count above tap count");
	a_run_reads: assert property (@(posedge clk) disable iff (!arst_n)
		run_go |=> (state_q == ST_RUN))
		else $error("run transfer did not start a ring read");
`endif
endmodule
`default_nettype wire
